FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the exchange sort engine.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// If ante holds, cons must hold at the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ese_pkg.sv
// Shared constants and types of the exchange sort engine.
// No dependencies.
package ese_pkg;

    // Default store depth, in elements
    localparam int ESE_MAX_ITEMS = 64;

    // Width of one stored element
    localparam int ESE_WORD_W = 32;

    typedef logic signed [ESE_WORD_W-1:0] t_word;

endpackage

FILE: rtl/exchange_sort_engine.sv
// Exchange sort engine: collects a list of signed 32-bit values, one per
// start transaction, and on the item marked last sorts it ascending and
// streams it back. A list element is taken whenever start is high while
// busy is low. After the last item busy stays high while the list is sorted
// and emitted (one element skips the sort): each outer position but the
// last fetches its element, compares it with every later one and writes
// it back; then one result per cycle is emitted. The sort rate is set by
// the single RAM read port, one compare per cycle. Results appear on
// o_sorted_value for exactly one cycle each, marked by o_strobe, and cannot
// be stalled; the final result of a list shows o_last_result and may
// coincide with the first item of the next list. Items beyond MAX_ITEMS are
// dropped and every result of that list shows o_overflowed.
// Depends on ese_pkg, ese_ram and assert_macros.svh.
`include "assert_macros.svh"

module exchange_sort_engine
    import ese_pkg::*;
#(
    parameter int MAX_ITEMS = ESE_MAX_ITEMS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ESE_WORD_W-1:0] i_value,
    input  logic                         i_last_item,
    output logic                         o_strobe,
    output logic signed [ESE_WORD_W-1:0] o_sorted_value,
    output logic                         o_last_result,
    output logic                         o_overflowed
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_CW = CW'(MAX_ITEMS);

    typedef enum logic [2:0] {
        S_LOAD,
        S_OUTER,
        S_LATCH,
        S_INNER,
        S_WB,
        S_EMIT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_drop, n_drop;
    logic [AW-1:0] r_outer, n_outer;
    logic [AW-1:0] r_inner, n_inner;
    t_word         r_outer_val, n_outer_val;
    logic          r_strobe, n_strobe;
    logic          r_out_last, n_out_last;
    logic          r_out_drop, n_out_drop;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_word           wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [ESE_WORD_W-1:0] rd_data;
    logic [CW-1:0]   inner_next;

    // element store
    ese_ram #(
        .WIDTH (ESE_WORD_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign inner_next = CW'(r_inner) + CW'(1);

    // Sequencer. The current outer element lives in r_outer_val and is
    // written back once per outer pass; the schedule never reads an entry
    // in the cycle it is written, so no forwarding is needed.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_outer     = r_outer;
        n_inner     = r_inner;
        n_outer_val = r_outer_val;
        n_strobe    = 1'b0;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;
        wr_en       = 1'b0;
        wr_addr     = r_inner;
        wr_data     = r_outer_val;
        rd_en       = 1'b0;
        rd_addr     = r_inner;

        case (r_state)
            S_LOAD: begin
                if (start) begin
                    if (r_count < MAX_CW) begin
                        wr_en   = 1'b1;
                        wr_addr = r_count[AW-1:0];
                        wr_data = i_value;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_item) begin
                        n_outer = '0;
                        n_inner = '0;
                        if (n_count > CW'(1)) begin
                            n_state = S_OUTER;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end

            // fetch the first outer element
            S_OUTER: begin
                rd_en   = 1'b1;
                rd_addr = r_outer;
                n_state = S_LATCH;
            end

            // capture outer element, fetch first inner one
            S_LATCH: begin
                n_outer_val = t_word'(rd_data);
                rd_en       = 1'b1;
                rd_addr     = r_outer + AW'(1);
                n_inner     = rd_addr;
                n_state     = S_INNER;
            end

            // compare-swap against the inner element arriving now
            S_INNER: begin
                if (r_outer_val > $signed(rd_data)) begin
                    wr_en       = 1'b1;
                    wr_addr     = r_inner;
                    wr_data     = r_outer_val;
                    n_outer_val = t_word'(rd_data);
                end
                if (inner_next < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_inner + AW'(1);
                    n_inner = rd_addr;
                end else begin
                    n_state = S_WB;
                end
            end

            // write back the outer element, then start the next outer pass or the output stream
            S_WB: begin
                wr_en   = 1'b1;
                wr_addr = r_outer;
                wr_data = r_outer_val;
                if (CW'(r_outer) + CW'(2) < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_outer + AW'(1);
                    n_outer = rd_addr;
                    n_state = S_LATCH;
                end else begin
                    n_inner = '0;
                    n_state = S_EMIT;
                end
            end

            // stream the list out, one read per cycle
            S_EMIT: begin
                rd_en      = 1'b1;
                rd_addr    = r_inner;
                n_strobe   = 1'b1;
                n_out_last = (inner_next == r_count);
                n_out_drop = r_drop;
                if (inner_next == r_count) begin
                    n_state = S_LOAD;
                    n_count = '0;
                    n_drop  = 1'b0;
                    n_inner = '0;
                    n_outer = '0;
                end else begin
                    n_inner = r_inner + AW'(1);
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_outer  <= '0;
            r_inner  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_outer  <= n_outer;
            r_inner  <= n_inner;
            r_strobe <= n_strobe;
        end
        r_outer_val <= n_outer_val;
        r_out_last  <= n_out_last;
        r_out_drop  <= n_out_drop;
    end

    assign busy           = (r_state != S_LOAD);
    assign o_strobe       = r_strobe;
    assign o_sorted_value = t_word'(rd_data);
    assign o_last_result  = r_out_last;
    assign o_overflowed   = r_out_drop;

    // checks
    `ASSERT_ALWAYS(a_no_rw_same_entry, !(wr_en && rd_en && (wr_addr == rd_addr)),
        "element RAM read and written at the same entry")
    `ASSERT_ALWAYS(a_count_in_range, r_count <= MAX_CW, "element count beyond store depth")
    `ASSERT_NEXT(a_results_contiguous, o_strobe && !o_last_result, o_strobe,
        "gap inside a result stream")
    `ASSERT_NEXT(a_last_starts_work, start && !busy && i_last_item, busy,
        "last item did not start the sort")

endmodule

FILE: rtl/ese_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on ese_pkg for the default word width and depth.
module ese_ram
    import ese_pkg::*;
#(
    parameter int WIDTH = ESE_WORD_W,
    parameter int DEPTH = ESE_MAX_ITEMS,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: tb/tb_exchange_sort_engine.sv
// Testbench for exchange_sort_engine: sends lists of signed words, predicts the
// sorted output stream and checks every strobed result against it.
// Depends on ese_pkg and the exchange_sort_engine RTL.
module tb_exchange_sort_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import ese_pkg::*;

    localparam int GAP_MAX      = 14;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 20;
    localparam int REPORT_MAX   = 10;

    localparam t_word WORD_MIN = 32'sh8000_0000;
    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;

    // One expected output transaction
    typedef struct {
        t_word value;
        logic  last;
        logic  ovf;
    } t_sorted_exp;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  start       = 1'b0;
    t_word i_value     = '0;
    logic  i_last_item = 1'b0;
    logic  busy;
    logic  o_strobe;
    t_word o_sorted_value;
    logic  o_last_result;
    logic  o_overflowed;

    // Predictor state: the list being collected
    t_word       list_buf[ESE_MAX_ITEMS];
    int unsigned list_len     = 0;
    bit          list_dropped = 1'b0;

    t_sorted_exp sorted_expected_q[$];

    int unsigned mismatch_cnt   = 0;
    int unsigned results_seen   = 0;
    int unsigned items_sent     = 0;
    int unsigned lists_sent     = 0;
    int unsigned overflow_lists = 0;
    bit          no_gap         = 1'b0;

    exchange_sort_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last_item    (i_last_item),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_last_result  (o_last_result),
        .o_overflowed   (o_overflowed)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Store one accepted element; on the last one, sort and queue the output stream
    function automatic void predict_element(t_word v, logic last);
        t_word       tmp;
        t_sorted_exp e;
        if (list_len < ESE_MAX_ITEMS) begin
            list_buf[list_len] = v;
            list_len++;
        end else begin
            list_dropped = 1'b1;
        end
        if (last) begin
            // exchange sort, signed compare
            for (int o = 0; o + 1 < int'(list_len); o++) begin
                for (int k = o + 1; k < int'(list_len); k++) begin
                    if (list_buf[o] > list_buf[k]) begin
                        tmp         = list_buf[o];
                        list_buf[o] = list_buf[k];
                        list_buf[k] = tmp;
                    end
                end
            end
            for (int k = 0; k < int'(list_len); k++) begin
                e.value = list_buf[k];
                e.last  = (k + 1 == int'(list_len));
                e.ovf   = list_dropped;
                sorted_expected_q.push_back(e);
            end
            if (list_dropped)
                overflow_lists++;
            lists_sent++;
            list_len     = 0;
            list_dropped = 1'b0;
        end
    endfunction

    // Drive one input transaction and wait until the engine takes it
    task automatic send_element(t_word v, logic last);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_value     <= v;
        i_last_item <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_element(v, last);
        items_sent++;
    endtask

    task automatic send_list(input t_word vals[$]);
        foreach (vals[k])
            send_element(vals[k], k == vals.size() - 1);
    endtask

    // Hold the sender off until every queued result has been seen
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sorted_expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Mix of full-range, clustered (duplicates) and extreme values
    function automatic t_word rand_word();
        case ($urandom_range(0, 3))
            0: return t_word'($urandom_range(0, 16)) - 8;
            1: begin
                case ($urandom_range(0, 3))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return t_word'($urandom());
        endcase
    endfunction

    task automatic test_directed_lists();
        send_list('{WORD_MIN});
        send_list('{WORD_MAX, WORD_MIN});
        send_list('{0, WORD_MAX, -1, WORD_MIN, 1, WORD_MIN + 1, WORD_MAX - 1});
        send_list('{5, -3, 5, 5, -3});
        send_list('{-2, -1, 0, 1, 2});
        send_list('{4, 3, 2, 1});
        wait_drained();
    endtask

    task automatic test_random_lists();
        t_word       vals[$];
        int unsigned len;
        int unsigned sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            vals.delete();
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16)
                                              : $urandom_range(1, 8);
            repeat (len) vals.push_back(rand_word());
            no_gap = ($urandom_range(0, 3) == 0);
            send_list(vals);
            sent += len;
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        no_gap = 1'b0;
    endtask

    // Fill the store, then drop two more; the last dropped one carries last_item
    task automatic test_store_overflow();
        t_word vals[$];
        repeat (ESE_MAX_ITEMS + 2) vals.push_back(t_word'($urandom()));
        send_list(vals);
        wait_drained();
    endtask

    // Compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_sorted_exp e;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (sorted_expected_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("ERROR: unexpected result value=%0d last=%0b ovf=%0b",
                             o_sorted_value, o_last_result, o_overflowed);
            end else begin
                e = sorted_expected_q.pop_front();
                if (o_sorted_value !== e.value || o_last_result !== e.last ||
                    o_overflowed !== e.ovf) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display({"ERROR: result %0d exp value=%0d last=%0b ovf=%0b",
                                  " got value=%0d last=%0b ovf=%0b"},
                                 results_seen, e.value, e.last, e.ovf,
                                 o_sorted_value, o_last_result, o_overflowed);
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_lists();
        test_random_lists();
        test_store_overflow();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sorted_expected_q.size() != 0) begin
            mismatch_cnt++;
            $display("ERROR: %0d expected results never arrived", sorted_expected_q.size());
        end

        $display("Sent %0d lists (%0d elements), checked %0d results.",
                 lists_sent, items_sent, results_seen);
        $display("%0d list(s) overflowed the store; %0d mismatch(es).",
                 overflow_lists, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #(3_000_000);
        $display("ERROR: timeout");
        $display("Regression FAIL");
        $finish;
    end

endmodule
